@@ hw/rtl/bpa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the bitmap page allocator.
// No dependencies; every other file of the block imports this package.
package bpa_pkg;

    // Default configuration, used as the parameter defaults of the design modules.
    localparam int DEF_WORD_COUNT = 16384;
    localparam int DEF_PAGE_BYTES = 4096;

    // Fixed geometry of the bitmap and of the address fields.
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int ADDR_W    = 32;
    // A rounded-up end address needs one bit more than a byte address.
    localparam int QUO_W     = ADDR_W + 1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MARK  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_NONE = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    // Dividend source for the page-number divider.
    typedef enum logic [1:0] {
        DSEL_FREE  = 2'd0,
        DSEL_START = 2'd1,
        DSEL_END   = 2'd2
    } t_div_sel;

    // Kind of bitmap write issued in a cycle.
    typedef enum logic [2:0] {
        WR_OFF   = 3'd0,
        WR_CLEAR = 3'd1,
        WR_FREE  = 3'd2,
        WR_MARK  = 3'd3,
        WR_ALLOC = 3'd4
    } t_wr_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     scan_init;
        logic     rd;
        logic     scan_chk;
        logic     scan_next;
        logic     div_start;
        t_div_sel div_sel;
        logic     save_a;
        logic     save_b;
        logic     ptr_init;
        logic     ptr_next;
        t_wr_kind wr;
        logic     res_load;
        t_status  res_status;
        logic     res_use_addr;
    } t_cmd;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic scan_end;
        logic word_full;
        logic page_over;
        logic div_done;
        logic free_bad;
        logic mark_bad;
        logic mark_empty;
        logic mark_last;
    } t_stat;

endpackage

@@ hw/rtl/bitmap_page_allocator.sv @@
`timescale 1ns / 1ps
// One transaction is worked at a time and the next is accepted the cycle after the result
// is loaded; a result the sink has not taken holds the block in its response state. Reset
// (synchronous, active low) starts a clearing pass that zeroes the bitmap; no request is
// taken until then.
//
// Bitmap page-frame allocator, first fit. One used bit per page is held in WORD_COUNT
// words of 64 bits in a single memory. Page p sits in word p / 64, bit p % 64.
//
// The block is split into a controller state machine (bpa_ctrl) and a datapath
// (bpa_datapath) that holds the bitmap memory, the word pointer, the scan hint, a
// page-size divider and the result register. They talk only through the command and
// status structs of bpa_pkg.
//
// Allocate reads each word and then checks it, from the scan hint upward. Every word below
// the hint is known to be full, so a scan never revisits them; a free below the hint
// pulls the hint back down. The lowest clear bit of the first non-full word is set and
// its page address (page number times PAGE_BYTES) is returned with status done, or
// status "no free page" with a zero address when every managed page is used.
//
// Free and mark turn byte addresses into page numbers with a constant divider that
// multiplies by the rounded-up reciprocal of PAGE_BYTES, so any page size in range is
// handled exactly. Free clears one bit. Mark walks the words between the
// rounded-down start page and the rounded-up end page with a read-modify-write of each
// word, using edge masks on the first and last word. Out-of-range pages, reversed ranges
// and unknown operations leave the bitmap alone and report the error status.
//
// A finished result sits in an output register while the next request is accepted.
module bitmap_page_allocator #(
    parameter int WORD_COUNT = bpa_pkg::DEF_WORD_COUNT,
    parameter int PAGE_BYTES = bpa_pkg::DEF_PAGE_BYTES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Request channel.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: free_address[31:0], range_start[63:32], range_end[95:64].
    input  logic [95:0]  s_axis_tdata,
    // tuser from bit 0: operation[1:0].
    input  logic [1:0]   s_axis_tuser,
    // Result channel.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: page_address[31:0].
    output logic [31:0]  m_axis_tdata,
    // tuser from bit 0: status[1:0].
    output logic [1:0]   m_axis_tuser
);
    import bpa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // The controller owns both handshakes; the datapath captures the request payload
    // when the controller issues its load command in the accepting cycle.
    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    bpa_datapath #(
        .WORD_COUNT (WORD_COUNT),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_free_address (s_axis_tdata[ADDR_W-1:0]),
        .i_range_start  (s_axis_tdata[2*ADDR_W-1:ADDR_W]),
        .i_range_end    (s_axis_tdata[3*ADDR_W-1:2*ADDR_W]),
        .o_page_address (m_axis_tdata),
        .o_status       (m_axis_tuser)
    );

endmodule

@@ hw/rtl/bpa_divider.sv @@
`timescale 1ns / 1ps
// Divider by a constant page size, done as a multiplication by the rounded-up reciprocal.
// Depends on bpa_pkg for the dividend width.
module bpa_divider #(
    parameter int DIVISOR = bpa_pkg::DEF_PAGE_BYTES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [bpa_pkg::QUO_W-1:0] i_dividend,
    output logic [bpa_pkg::QUO_W-1:0] o_quotient,
    output logic                    o_done
);
    import bpa_pkg::*;

    // With L = ceil(log2(DIVISOR)) and M = ceil(2^(QUO_W+L) / DIVISOR), the product of the
    // dividend and M shifted down by QUO_W+L is the exact quotient for every dividend.
    localparam int     L_W   = $clog2(DIVISOR);
    localparam int     SHIFT = QUO_W + L_W;
    localparam int     M_W   = QUO_W + 1;
    localparam longint M_VAL = ((longint'(1) <<< SHIFT) + longint'(DIVISOR) - 1)
                               / longint'(DIVISOR);
    localparam int     LO_W  = QUO_W - QUO_W / 2;
    localparam int     HI_W  = QUO_W - LO_W;
    localparam int     PL_W  = M_W + LO_W;
    localparam int     PH_W  = M_W + HI_W;
    localparam int     P_W   = M_W + QUO_W;
    localparam logic [M_W-1:0] M_C = M_W'(M_VAL);

    logic [QUO_W-1:0] r_num;
    logic [PL_W-1:0]  r_p_lo;
    logic [PH_W-1:0]  r_p_hi;
    logic [P_W-1:0]   r_acc;
    logic             r_mul;
    logic             r_sum;
    logic             r_done;
    logic [PL_W-1:0]  prod_lo;
    logic [PH_W-1:0]  prod_hi;

    // The dividend is split in two halves so each product stays narrow.
    assign prod_lo = PL_W'(M_C) * PL_W'(r_num[LO_W-1:0]);
    assign prod_hi = PH_W'(M_C) * PH_W'(r_num[QUO_W-1:LO_W]);

    // First the partial products are registered, then their sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_sum  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mul  <= i_start;
            r_sum  <= r_mul;
            r_done <= r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
        end
        if (r_mul) begin
            r_p_lo <= prod_lo;
            r_p_hi <= prod_hi;
        end
        if (r_sum) begin
            r_acc <= P_W'(r_p_lo) + (P_W'(r_p_hi) << LO_W);
        end
    end

    assign o_quotient = QUO_W'(r_acc >> SHIFT);
    assign o_done     = r_done;

endmodule

@@ hw/rtl/bpa_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the page allocator: bitmap memory, pointers, masks and result register.
// Depends on bpa_pkg and instantiates bpa_divider.
module bpa_datapath #(
    parameter int WORD_COUNT = bpa_pkg::DEF_WORD_COUNT,
    parameter int PAGE_BYTES = bpa_pkg::DEF_PAGE_BYTES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpa_pkg::t_cmd              i_cmd,
    output bpa_pkg::t_stat             o_stat,
    input  logic [bpa_pkg::ADDR_W-1:0] i_free_address,
    input  logic [bpa_pkg::ADDR_W-1:0] i_range_start,
    input  logic [bpa_pkg::ADDR_W-1:0] i_range_end,
    output logic [bpa_pkg::ADDR_W-1:0] o_page_address,
    output logic [1:0]                 o_status
);
    import bpa_pkg::*;

    // Managed pages: limited by the bitmap size and by the 32-bit address space.
    localparam longint BY_WORDS = longint'(WORD_COUNT) * WORD_BITS;
    localparam longint BY_ADDR  = (longint'(1) <<< ADDR_W) / PAGE_BYTES;
    localparam longint LIMIT    = (BY_WORDS < BY_ADDR) ? BY_WORDS : BY_ADDR;
    localparam longint WORD_LIM = (LIMIT + WORD_BITS - 1) / WORD_BITS;

    localparam int WI_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int WP_W = $clog2(WORD_COUNT + 1);
    localparam int PG_W = WP_W + BIT_W;
    localparam int PB_W = $clog2(PAGE_BYTES + 1);
    localparam int PR_W = PG_W + PB_W;

    localparam logic [63:0]          LIMIT_C    = 64'(LIMIT);
    localparam logic [WP_W-1:0]      WORD_LIM_C = WP_W'(WORD_LIM);
    localparam logic [WI_W-1:0]      CLR_LAST_C = WI_W'(WORD_COUNT - 1);
    localparam logic [PB_W-1:0]      PB_C       = PB_W'(PAGE_BYTES);
    localparam logic [QUO_W-1:0]     ROUND_C    = QUO_W'(PAGE_BYTES - 1);
    localparam logic [WORD_BITS-1:0] ONES       = '1;
    localparam logic [WORD_BITS-1:0] ONE        = WORD_BITS'(1);
    localparam logic [BIT_W-1:0]     TOP_BIT    = BIT_W'(WORD_BITS - 1);

    // Bitmap storage and its registered read port.
    logic [WORD_BITS-1:0] r_mem [WORD_COUNT];
    logic [WORD_BITS-1:0] r_rdata;

    logic [WI_W-1:0]   r_clr;
    logic [WP_W-1:0]   r_w;
    logic [WP_W-1:0]   n_w;
    logic [WP_W-1:0]   r_hint;
    logic [WP_W-1:0]   n_hint;
    logic [ADDR_W-1:0] r_faddr;
    logic [ADDR_W-1:0] r_rs;
    logic [ADDR_W-1:0] r_re;
    logic [QUO_W-1:0]  r_q_a;
    logic [QUO_W-1:0]  r_q_b;
    logic [WORD_BITS-1:0] r_bit_oh;
    logic [BIT_W-1:0]  r_bit_idx;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_res_addr;
    t_status           r_res_status;

    logic [QUO_W-1:0]     div_num;
    logic [QUO_W-1:0]     div_quo;
    logic                 div_done;
    logic [WORD_BITS-1:0] inv;
    logic [WORD_BITS-1:0] low_oh;
    logic [BIT_W-1:0]     low_idx;
    logic [PG_W-1:0]      page;
    logic [PR_W-1:0]      prod;
    logic [QUO_W-1:0]     qb_m1;
    logic [WP_W-1:0]      ws;
    logic [WP_W-1:0]      we;
    logic                 mark_last;
    logic [BIT_W-1:0]     lo;
    logic [BIT_W-1:0]     hi;
    logic [WORD_BITS-1:0] mark_mask;
    logic [WORD_BITS-1:0] free_mask;
    logic                 wr_en;
    logic [WI_W-1:0]      wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // Page-number divider, shared by free and both ends of a mark.
    always_comb begin
        case (i_cmd.div_sel)
            DSEL_FREE:  div_num = {1'b0, r_faddr};
            DSEL_START: div_num = {1'b0, r_rs};
            DSEL_END:   div_num = {1'b0, r_re} + ROUND_C;
            default:    div_num = '0;
        endcase
    end

    bpa_divider #(
        .DIVISOR (PAGE_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    // Lowest free bit of the word under scan.
    assign inv    = ~r_rdata;
    assign low_oh = inv & (~inv + ONE);

    always_comb begin
        low_idx = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (low_oh[j]) begin
                low_idx = low_idx | BIT_W'(j);
            end
        end
    end

    assign page = {r_w, r_bit_idx};
    assign prod = PR_W'(page) * PR_W'(PB_C);

    // Word range and edge masks of a mark, and the bit mask of a free.
    assign qb_m1     = r_q_b - 1'b1;
    assign ws        = r_q_a[BIT_W +: WP_W];
    assign we        = qb_m1[BIT_W +: WP_W];
    assign mark_last = (r_w == we);
    assign lo        = (r_w == ws) ? r_q_a[BIT_W-1:0] : '0;
    assign hi        = mark_last ? qb_m1[BIT_W-1:0] : TOP_BIT;
    assign mark_mask = (ONES << lo) & (ONES >> (TOP_BIT - hi));
    assign free_mask = ~(ONE << r_q_a[BIT_W-1:0]);

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_w[WI_W-1:0];
        case (i_cmd.wr)
            WR_CLEAR: begin
                wr_addr = r_clr;
                wr_data = '0;
            end
            WR_FREE:  wr_data = r_rdata & free_mask;
            WR_MARK:  wr_data = r_rdata | mark_mask;
            WR_ALLOC: wr_data = r_rdata | r_bit_oh;
            default: begin
                wr_en   = 1'b0;
                wr_data = r_rdata;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_w[WI_W-1:0]];
        end
    end

    // Word pointer and scan hint. Every word below the hint is known full.
    always_comb begin
        n_w    = r_w;
        n_hint = r_hint;
        if (i_cmd.scan_init) begin
            n_w = r_hint;
        end else if (i_cmd.ptr_init) begin
            n_w = ws;
        end else if (i_cmd.scan_next || i_cmd.ptr_next) begin
            n_w = r_w + 1'b1;
        end
        if (i_cmd.scan_next) begin
            n_hint = r_w + 1'b1;
        end else if (i_cmd.wr == WR_FREE && ws < r_hint) begin
            n_hint = ws;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_w    <= '0;
            r_hint <= '0;
        end else begin
            r_w    <= n_w;
            r_hint <= n_hint;
            if (i_cmd.wr == WR_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_faddr <= i_free_address;
            r_rs    <= i_range_start;
            r_re    <= i_range_end;
        end
        if (i_cmd.save_a) begin
            r_q_a <= div_quo;
        end
        if (i_cmd.save_b) begin
            r_q_b <= div_quo;
        end
        if (i_cmd.scan_chk) begin
            r_bit_oh  <= low_oh;
            r_bit_idx <= low_idx;
        end
        if (i_cmd.wr == WR_ALLOC) begin
            r_addr <= ADDR_W'(prod);
        end
        if (i_cmd.res_load) begin
            r_res_addr   <= i_cmd.res_use_addr ? r_addr : '0;
            r_res_status <= i_cmd.res_status;
        end
    end

    assign o_stat.clr_last   = (r_clr == CLR_LAST_C);
    assign o_stat.scan_end   = (r_w >= WORD_LIM_C);
    assign o_stat.word_full  = &r_rdata;
    assign o_stat.page_over  = (64'(page) >= LIMIT_C);
    assign o_stat.div_done   = div_done;
    assign o_stat.free_bad   = (64'(r_q_a) >= LIMIT_C);
    assign o_stat.mark_bad   = (r_re < r_rs) || (64'(r_q_b) > LIMIT_C);
    assign o_stat.mark_empty = (r_q_a >= r_q_b);
    assign o_stat.mark_last  = mark_last;

    assign o_page_address = r_res_addr;
    assign o_status       = r_res_status;

endmodule

@@ hw/rtl/bpa_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the page allocator: sequences clear, scan, divide and update.
// Depends on bpa_pkg for the command and status structs.
module bpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_op,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bpa_pkg::t_cmd  o_cmd,
    input  bpa_pkg::t_stat i_stat
);
    import bpa_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_ARD   = 13'b0000000000100,
        S_ACHK  = 13'b0000000001000,
        S_ASET  = 13'b0000000010000,
        S_DSA   = 13'b0000000100000,
        S_DWA   = 13'b0000001000000,
        S_DSB   = 13'b0000010000000,
        S_DWB   = 13'b0000100000000,
        S_CHECK = 13'b0001000000000,
        S_WRD   = 13'b0010000000000,
        S_WMOD  = 13'b0100000000000,
        S_RESP  = 13'b1000000000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_op     r_op;
    t_op     n_op;
    t_status r_res;
    t_status n_res;
    logic    r_use_addr;
    logic    n_use_addr;
    logic    r_out_valid;
    logic    n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_res       = r_res;
        n_use_addr  = r_use_addr;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.res_status   = r_res;
        o_cmd.res_use_addr = r_use_addr;
        case (r_state)
            S_CLEAR: begin
                o_cmd.wr = WR_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    n_op            = t_op'(i_op);
                    n_res           = ST_DONE;
                    n_use_addr      = 1'b0;
                    case (i_op)
                        OP_ALLOC: n_state = S_ARD;
                        OP_FREE:  n_state = S_DSA;
                        OP_MARK:  n_state = S_DSA;
                        default: begin
                            n_res   = ST_BAD;
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_ARD: begin
                if (i_stat.scan_end) begin
                    n_res   = ST_NONE;
                    n_state = S_RESP;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_ACHK;
                end
            end
            S_ACHK: begin
                o_cmd.scan_chk = 1'b1;
                if (i_stat.word_full) begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_ARD;
                end else begin
                    n_state = S_ASET;
                end
            end
            S_ASET: begin
                if (i_stat.page_over) begin
                    n_res = ST_NONE;
                end else begin
                    o_cmd.wr   = WR_ALLOC;
                    n_use_addr = 1'b1;
                end
                n_state = S_RESP;
            end
            S_DSA: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = (r_op == OP_FREE) ? DSEL_FREE : DSEL_START;
                n_state         = S_DWA;
            end
            S_DWA: begin
                if (i_stat.div_done) begin
                    o_cmd.save_a = 1'b1;
                    n_state      = (r_op == OP_MARK) ? S_DSB : S_CHECK;
                end
            end
            S_DSB: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_END;
                n_state         = S_DWB;
            end
            S_DWB: begin
                if (i_stat.div_done) begin
                    o_cmd.save_b = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.ptr_init = 1'b1;
                if (r_op == OP_FREE) begin
                    if (i_stat.free_bad) begin
                        n_res   = ST_BAD;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_WRD;
                    end
                end else if (i_stat.mark_bad) begin
                    n_res   = ST_BAD;
                    n_state = S_RESP;
                end else if (i_stat.mark_empty) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_WRD;
                end
            end
            S_WRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WMOD;
            end
            S_WMOD: begin
                if (r_op == OP_FREE) begin
                    o_cmd.wr = WR_FREE;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.wr = WR_MARK;
                    if (i_stat.mark_last) begin
                        n_state = S_RESP;
                    end else begin
                        o_cmd.ptr_next = 1'b1;
                        n_state        = S_WRD;
                    end
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_res      <= n_res;
        r_use_addr <= n_use_addr;
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_page_allocator: directed and random requests
// with a scoreboard that keeps its own copy of the page bitmap. Depends on bpa_pkg.
module tb;
    import bpa_pkg::*;

    localparam int WORD_COUNT = DEF_WORD_COUNT;
    localparam int PAGE_BYTES = DEF_PAGE_BYTES;

    // Managed pages: the smaller of what the words hold and what fits below 4 GiB.
    localparam longint unsigned PAGES_BY_WORDS = 64'(WORD_COUNT) * 64;
    localparam longint unsigned PAGES_BY_ADDR  = (64'd1 << 32) / PAGE_BYTES;
    localparam longint unsigned PAGE_LIMIT     =
        (PAGES_BY_WORDS < PAGES_BY_ADDR) ? PAGES_BY_WORDS : PAGES_BY_ADDR;

    // The package enum has no member for the spare operation code.
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    // Random traffic is aimed mostly at the low pages so that allocations, frees and
    // marks keep landing on the same words.
    localparam int WINDOW_PAGES  = 4096;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int CHUNK_ITEMS   = 250;
    // A mark or an allocation over a full bitmap can walk every word, as does the clearing
    // pass after reset; the limit leaves ample room for either.
    localparam int STALL_LIMIT   = 150000;
    // Ample margin after the last result, well beyond the run of a small mark.
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        logic [31:0] page_addr;
        t_status     status;
    } t_page_result;

    // Scoreboard: models the bitmap and holds the results still owed by the block.
    class page_bitmap_scoreboard;
        bit [63:0]    used_words [WORD_COUNT];
        // Every word below this index is known to be full.
        int unsigned  full_below;
        t_page_result expected_results [$];
        int           errors;
        int           checked;
        int           granted;
        int           exhausted;
        int           released;
        int           marked;
        int           rejected;

        function bit take_lowest_free(output logic [31:0] addr);
            longint unsigned page;
            int              b;
            addr = '0;
            while (full_below < WORD_COUNT && used_words[full_below] == '1)
                full_below++;
            if (full_below >= WORD_COUNT || 64'(full_below) * 64 >= PAGE_LIMIT)
                return 1'b0;
            b = 0;
            while (b < 63 && used_words[full_below][b])
                b++;
            page = 64'(full_below) * 64 + 64'(b);
            if (page >= PAGE_LIMIT)
                return 1'b0;
            used_words[full_below][b] = 1'b1;
            addr = 32'(page * PAGE_BYTES);
            return 1'b1;
        endfunction

        function void note_request(logic [1:0] op, logic [31:0] free_addr,
                                   logic [31:0] start_addr, logic [31:0] end_addr);
            t_page_result    want;
            longint unsigned page;
            longint unsigned first_page;
            longint unsigned stop_page;
            want.page_addr = '0;
            want.status    = ST_DONE;
            case (op)
                OP_ALLOC: begin
                    if (take_lowest_free(want.page_addr)) begin
                        granted++;
                    end else begin
                        want.page_addr = '0;
                        want.status    = ST_NONE;
                        exhausted++;
                    end
                end
                OP_FREE: begin
                    page = 64'(free_addr) / PAGE_BYTES;
                    if (page >= PAGE_LIMIT) begin
                        want.status = ST_BAD;
                        rejected++;
                    end else begin
                        used_words[page >> 6][page[5:0]] = 1'b0;
                        // A freed word may no longer be full, so scans restart there.
                        if ((page >> 6) < full_below)
                            full_below = int'(page >> 6);
                        released++;
                    end
                end
                OP_MARK: begin
                    first_page = 64'(start_addr) / PAGE_BYTES;
                    stop_page  = (64'(end_addr) + PAGE_BYTES - 1) / PAGE_BYTES;
                    if (end_addr < start_addr || stop_page > PAGE_LIMIT) begin
                        want.status = ST_BAD;
                        rejected++;
                    end else begin
                        for (page = first_page; page < stop_page; page++)
                            used_words[page >> 6][page[5:0]] = 1'b1;
                        marked++;
                    end
                end
                default: begin
                    want.status = ST_BAD;
                    rejected++;
                end
            endcase
            expected_results.push_back(want);
        endfunction

        function void check_result(logic [31:0] got_addr, logic [1:0] got_status);
            t_page_result want;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, page_address %h status %0d",
                         $time, got_addr, got_status);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got_addr !== want.page_addr) begin
                errors++;
                $display("%0t: page_address mismatch, expected %h actual %h",
                         $time, want.page_addr, got_addr);
            end
            if (got_status !== want.status) begin
                errors++;
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, want.status, got_status);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // From bit 0: free_address[31:0], range_start[63:32], range_end[95:64].
    logic [95:0] s_axis_tdata;
    // From bit 0: operation[1:0].
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // From bit 0: page_address[31:0].
    logic [31:0] m_axis_tdata;
    // From bit 0: status[1:0].
    logic [1:0]  m_axis_tuser;

    page_bitmap_scoreboard sb = new;

    // Upper bounds of the per-transaction wait drawn by the sender and the receiver.
    int unsigned src_idle_max  = 0;
    int unsigned sink_idle_max = 0;
    int unsigned stall_cycles  = 0;

    bitmap_page_allocator #(
        .WORD_COUNT(WORD_COUNT),
        .PAGE_BYTES(PAGE_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Inputs move on the falling edge. A request is noted in the scoreboard at the
    // rising edge where its transaction completes. Back-to-back requests change the
    // data without dropping tvalid, so each step sees one assignment per signal.
    task automatic send_request(input logic [1:0] op, input logic [31:0] free_addr,
                                input logic [31:0] start_addr, input logic [31:0] end_addr);
        int unsigned gap;
        gap = $urandom_range(src_idle_max, 0);
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {end_addr, start_addr, free_addr};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, free_addr, start_addr, end_addr);
    endtask

    // Drops tvalid and holds off until the block has delivered every owed result.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // One random request. Most are well-formed allocations, frees and marks around the
    // low pages; the rest are top-of-memory marks, reversed ranges, the spare
    // operation code and frees anywhere in the address space.
    task automatic send_random_request();
        int unsigned pick;
        int unsigned sel;
        int unsigned page;
        int unsigned span;
        logic [31:0] start_addr;
        logic [31:0] end_addr;
        pick = $urandom_range(99, 0);
        if (pick < 40) begin
            send_request(OP_ALLOC, $urandom, $urandom, $urandom);
        end else if (pick < 72) begin
            page = $urandom_range(WINDOW_PAGES - 1, 0);
            send_request(OP_FREE, page * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1, 0),
                         $urandom, $urandom);
        end else if (pick < 87) begin
            page       = $urandom_range(WINDOW_PAGES - 1, 0);
            start_addr = page * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1, 0);
            sel        = $urandom_range(99, 0);
            if (sel < 80)
                span = $urandom_range(3 * PAGE_BYTES, 0);
            else if (sel < 98)
                span = $urandom_range(64 * PAGE_BYTES, 0);
            else
                span = $urandom_range(512 * PAGE_BYTES, 0);
            send_request(OP_MARK, $urandom, start_addr, start_addr + span);
        end else if (pick < 90) begin
            // Ranges in the top megabyte of memory, end address up to all ones.
            start_addr = 32'hFFF0_0000 + $urandom_range(32'h000F_FFFF, 0);
            end_addr   = start_addr + $urandom_range(32'hFFFF_FFFF - start_addr, 0);
            send_request(OP_MARK, $urandom, start_addr, end_addr);
        end else if (pick < 93) begin
            start_addr = $urandom | 32'd1;
            end_addr   = $urandom_range(start_addr - 1, 0);
            send_request(OP_MARK, $urandom, start_addr, end_addr);
        end else if (pick < 96) begin
            send_request(OP_UNKNOWN, $urandom, $urandom, $urandom);
        end else begin
            send_request(OP_FREE, $urandom, $urandom, $urandom);
        end
    endtask

    // Receiver: before each result it draws a stall and then waits with tready high.
    initial begin
        int unsigned gap;
        m_axis_tready = 1'b0;
        forever begin
            gap = $urandom_range(sink_idle_max, 0);
            @(negedge i_clk);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Every accepted result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Watchdog: counts cycles in which neither side completes a transaction.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles, %0d results owed",
                     $time, stall_cycles, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ALLOC;
        i_rst_n       = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The block refuses requests until its clearing pass is over.
        src_idle_max  = 8;
        sink_idle_max = 8;
        send_request(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Unaligned free of page 0, then the same page again while it is already free.
        send_request(OP_FREE, 32'h0000_0FFF, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_FREE, 32'h0000_0FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        // Equal ends: aligned marks nothing, unaligned marks the page it sits in.
        send_request(OP_MARK, 32'h0000_0000, 32'h0000_5000, 32'h0000_5000);
        send_request(OP_MARK, 32'h0000_0000, 32'h0000_7123, 32'h0000_7123);
        send_request(OP_MARK, 32'hFFFF_FFFF, 32'h0000_2001, 32'h0000_4001);
        send_request(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_MARK, 32'h0000_0000, 32'h0000_9000, 32'h0000_8FFF);
        send_request(OP_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        // The top page; an end address of all ones rounds up to the page count itself.
        send_request(OP_MARK, 32'h0000_0000, 32'hFFFF_F000, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'hFFFF_F000, 32'h0000_0000, 32'h0000_0000);
        // A range across three words, with edge masks on both ends.
        send_request(OP_MARK, 32'h0000_0000, 32'h0003_F000, 32'h0008_1000);
        send_request(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        // Freeing a page in a later word must not hide the lower free pages.
        send_request(OP_FREE, 32'h0004_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_MARK, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

        // Random part, in chunks that differ in how much each side idles.
        for (int chunk = 0; chunk * CHUNK_ITEMS < RANDOM_ITEMS; chunk++) begin
            src_idle_max  = chunk[0] ? 8 : 0;
            sink_idle_max = chunk[1] ? 8 : 0;
            for (int n = 0; n < CHUNK_ITEMS; n++)
                send_random_request();
            // Once in the middle the sender waits until the block has caught up.
            if (chunk == 3)
                drain_results();
        end

        // Closing part: a full bitmap. Kept last, since an allocation over a full
        // bitmap can walk all of it.
        drain_results();
        src_idle_max  = 8;
        sink_idle_max = 8;
        send_request(OP_MARK, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_FREE, 32'hFFFF_F123, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_FREE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d allocations granted, %0d refused on a full bitmap, %0d frees,",
                 sb.granted, sb.exhausted, sb.released);
        $display("%0d marks and %0d rejected requests; %0d results compared, %0d mismatches.",
                 sb.marked, sb.rejected, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
